FILE: rtl/core/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared constants for the bounded deque: default depth, field widths,
// command codes and status codes.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ_POS   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

endpackage

FILE: rtl/core/bounded_deque_with_value_removal_top.sv
// ----------------------------------------------------------------------------
// Bounded deque with value removal
// Double-ended queue of signed 32-bit values held in a circular on-chip
// store, with push and pop at both ends, removal of the first matching value
// and read by position.
// ----------------------------------------------------------------------------
// One request is handled at a time, and a new request is taken while the
// previous response still waits in the output register. Pushes and rejected
// requests go straight to the response state; pops and reads first pass
// through a read state to wait for the store's registered read port. A
// removal scans one entry per cycle from the front and then moves each later
// entry one place forward, one per cycle. The store has a single read port.
// The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_removal_top #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] command
   input  logic [31:0] req_tdata,   // [31:0] operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [39:0] rsp_tdata    // [31:0] data, [36:32] count, [39:37] zero
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SEARCH,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type                      state_ff;
   logic [PW-1:0]                  head_ff;
   logic [CW-1:0]                  occ_ff;
   logic [bdq_pkg::CMD_W-1:0]      cmd_ff;
   logic [bdq_pkg::DATA_W-1:0]     val_ff;
   logic [CW-1:0]                  k_ff;
   logic [CW-1:0]                  rptr_ff;
   logic [CW-1:0]                  wptr_ff;
   logic                           pend_ff;
   logic [bdq_pkg::STATUS_W-1:0]   res_status_ff;
   logic [bdq_pkg::DATA_W-1:0]     res_data_ff;
   logic                           rsp_valid_ff;
   logic [bdq_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [bdq_pkg::DATA_W-1:0]     rsp_data_ff;
   logic [bdq_pkg::COUNT_W-1:0]    rsp_count_ff;

   logic [bdq_pkg::DATA_W-1:0]     mem [DEPTH];
   logic [bdq_pkg::DATA_W-1:0]     rd_data_ff;
   logic                           mem_we;
   logic [PW-1:0]                  mem_waddr;
   logic [bdq_pkg::DATA_W-1:0]     mem_wdata;
   logic [PW-1:0]                  mem_raddr;

   logic                           is_full;
   logic                           is_empty;
   logic                           pos_bad;
   logic [PW-1:0]                  head_dec;
   logic [CW-1:0]                  pos_idx;

   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] hd,
                                             input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(hd) + (CW+1)'(k);
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   assign is_full  = (occ_ff == CW'(DEPTH));
   assign is_empty = (occ_ff == '0);
   assign pos_bad  = req_tdata[31] || (req_tdata == '0) || (req_tdata > 32'(occ_ff));
   assign head_dec = (head_ff == '0) ? PW'(DEPTH - 1) : head_ff - 1'b1;
   assign pos_idx  = req_tdata[CW-1:0] - 1'b1;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_data_ff};

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_of(head_ff, occ_ff);
      mem_wdata = req_tdata;
      mem_raddr = slot_of(head_ff, k_ff);
      case (state_ff)
         S_IDLE: begin
            case (req_tuser)
               bdq_pkg::CMD_PUSH_BACK: begin
                  mem_we = req_tvalid && !is_full;
               end
               bdq_pkg::CMD_PUSH_FRONT: begin
                  mem_we    = req_tvalid && !is_full;
                  mem_waddr = head_dec;
               end
               bdq_pkg::CMD_POP_BACK: begin
                  mem_raddr = slot_of(head_ff, occ_ff - 1'b1);
               end
               bdq_pkg::CMD_POP_FRONT: begin
                  mem_raddr = head_ff;
               end
               bdq_pkg::CMD_READ_POS: begin
                  mem_raddr = slot_of(head_ff, pos_idx);
               end
               default: begin
               end
            endcase
         end
         S_SEARCH: begin
            mem_raddr = slot_of(head_ff, k_ff);
         end
         S_SHIFT: begin
            mem_raddr = slot_of(head_ff, rptr_ff);
            mem_we    = pend_ff;
            mem_waddr = slot_of(head_ff, wptr_ff);
            mem_wdata = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff        <= req_tuser;
                  val_ff        <= req_tdata;
                  res_status_ff <= bdq_pkg::ST_OK;
                  res_data_ff   <= '0;
                  state_ff      <= S_RESP;
                  case (req_tuser)
                     bdq_pkg::CMD_PUSH_BACK: begin
                        if (is_full) begin
                           res_status_ff <= bdq_pkg::ST_FULL;
                        end else begin
                           occ_ff <= occ_ff + 1'b1;
                        end
                     end
                     bdq_pkg::CMD_PUSH_FRONT: begin
                        if (is_full) begin
                           res_status_ff <= bdq_pkg::ST_FULL;
                        end else begin
                           head_ff <= head_dec;
                           occ_ff  <= occ_ff + 1'b1;
                        end
                     end
                     bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_POP_FRONT: begin
                        if (is_empty) begin
                           res_status_ff <= bdq_pkg::ST_EMPTY;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     bdq_pkg::CMD_REMOVE: begin
                        if (is_empty) begin
                           res_status_ff <= bdq_pkg::ST_EMPTY;
                        end else begin
                           k_ff     <= '0;
                           pend_ff  <= 1'b0;
                           state_ff <= S_SEARCH;
                        end
                     end
                     bdq_pkg::CMD_READ_POS: begin
                        if (pos_bad) begin
                           res_status_ff <= bdq_pkg::ST_RANGE;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_READ: begin
               res_data_ff <= rd_data_ff;
               if (cmd_ff == bdq_pkg::CMD_POP_BACK) begin
                  occ_ff <= occ_ff - 1'b1;
               end else if (cmd_ff == bdq_pkg::CMD_POP_FRONT) begin
                  head_ff <= slot_of(head_ff, CW'(1));
                  occ_ff  <= occ_ff - 1'b1;
               end
               state_ff <= S_RESP;
            end
            S_SEARCH: begin
               k_ff    <= k_ff + 1'b1;
               pend_ff <= 1'b1;
               if (pend_ff && (rd_data_ff == val_ff)) begin
                  res_data_ff <= rd_data_ff;
                  rptr_ff     <= k_ff;
                  wptr_ff     <= k_ff - 1'b1;
                  pend_ff     <= 1'b0;
                  state_ff    <= S_SHIFT;
               end else if (pend_ff && (k_ff == occ_ff)) begin
                  res_status_ff <= bdq_pkg::ST_NOTFOUND;
                  pend_ff       <= 1'b0;
                  state_ff      <= S_RESP;
               end
            end
            S_SHIFT: begin
               if (rptr_ff < occ_ff) begin
                  rptr_ff <= rptr_ff + 1'b1;
               end
               if (pend_ff) begin
                  wptr_ff <= wptr_ff + 1'b1;
               end
               pend_ff <= (rptr_ff < occ_ff);
               if (!pend_ff && (rptr_ff >= occ_ff)) begin
                  occ_ff   <= occ_ff - 1'b1;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_data_ff   <= res_data_ff;
                  rsp_count_ff  <= bdq_pkg::COUNT_W'(occ_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH))
      else $error("Occupancy exceeds the depth.");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= PW'(DEPTH - 1))
      else $error("Head index is outside the store.");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == bdq_pkg::CMD_PUSH_BACK) && !is_full)
      |=> (occ_ff == CW'($past(occ_ff) + 1'b1)))
      else $error("Accepted push did not grow the occupancy.");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (wptr_ff < rptr_ff))
      else $error("Gap closing writes at or past its read position.");

endmodule
